// ===== hdl/min_max_range_normalizer_core_assert.svh =====
// Assertion macros shared by the min-max range normaliser modules.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef MIN_MAX_RANGE_NORMALIZER_CORE_ASSERT_SVH
`define MIN_MAX_RANGE_NORMALIZER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MMRN_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mmrn assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MMRN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mmrn assertion failed");

`endif

// ===== hdl/mmrn_pkg.sv =====
// Shared types, constants and helper functions for the min-max range normaliser.
// No dependencies.
package mmrn_pkg;

  localparam int FRAC_W    = 16;
  localparam int SPAN2_W   = 9;
  localparam int QUO_W     = FRAC_W + SPAN2_W;
  localparam int DIV_STEPS = QUO_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int PROD_W    = 32 + SPAN2_W;

  localparam logic [1:0] REG_RAW_FORMAT   = 2'd0;
  localparam logic [1:0] REG_TARGET_LEVEL = 2'd1;
  localparam logic [1:0] REG_HALF_SPAN    = 2'd2;

  localparam logic [1:0] FMT_8BIT  = 2'd0;
  localparam logic [1:0] FMT_10BIT = 2'd1;
  localparam logic [1:0] FMT_12BIT = 2'd2;
  localparam logic [1:0] FMT_16BIT = 2'd3;

  localparam logic MODE_GATHER    = 1'b0;
  localparam logic MODE_NORMALIZE = 1'b1;

  typedef struct packed {
    logic        mode;
    logic        first;
    logic [31:0] sample;
  } req_t;

  typedef struct packed {
    logic signed [33:0] value;
    logic               degenerate;
    logic               saturated;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic accept;
    logic prep;
    logic mul;
    logic div_step;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic req_norm;
    logic skip_div;
    logic out_free;
  } stat_t;

  function automatic logic [15:0] top_code(input logic [1:0] fmt);
    logic [15:0] code;
    case (fmt)
      FMT_8BIT:  code = 16'd255;
      FMT_10BIT: code = 16'd1023;
      FMT_12BIT: code = 16'd4095;
      FMT_16BIT: code = 16'd65535;
      default:   code = 16'd65535;
    endcase
    return code;
  endfunction

endpackage

// ===== hdl/min_max_range_normalizer_core.sv =====
// Top level of the min-max range normaliser: controller and datapath.
// Depends on mmrn_pkg, mmrn_ctrl and mmrn_datapath.
//
// A gather sample updates the running maximum and minimum and is taken without
// leaving the idle state, producing no result. A normalise sample passes through
// the prepare, multiply and finish states when the result is degenerate or lies
// outside the band, and through the divide state as well otherwise, where the
// radix-2 shift-subtract divider resolves one of 25 quotient bits per cycle.
// The result sits in an output register, so a new sample is taken while the
// previous result still awaits transfer. Configuration registers:
// 0 raw format, 1 target level, 2 half span; write them only while idle.
module min_max_range_normalizer_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [15:0]    cfg_data,
  input  logic           req_valid,
  output logic           req_stall,
  input  mmrn_pkg::req_t req,
  output logic           res_valid,
  input  logic           res_stall,
  output mmrn_pkg::res_t res
);

  mmrn_pkg::cmd_t  cmd;
  mmrn_pkg::stat_t stat;

  mmrn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  mmrn_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .res       (res),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ===== hdl/mmrn_ctrl.sv =====
// Sequencing state machine for the min-max range normaliser.
// Depends on mmrn_pkg and the shared assertion header.
`include "min_max_range_normalizer_core_assert.svh"

module mmrn_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  mmrn_pkg::stat_t stat,
  output mmrn_pkg::cmd_t  cmd
);

  mmrn_pkg::state_t               state, state_next;
  logic [mmrn_pkg::CNT_W-1:0]     count, count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mmrn_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    cmd        = '0;
    req_stall  = 1'b1;
    case (state)
      mmrn_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.accept = 1'b1;
          if (stat.req_norm) begin
            state_next = mmrn_pkg::ST_PREP;
          end
        end
      end
      mmrn_pkg::ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = mmrn_pkg::ST_MUL;
      end
      mmrn_pkg::ST_MUL: begin
        cmd.mul    = 1'b1;
        count_next = '0;
        state_next = stat.skip_div ? mmrn_pkg::ST_FIN : mmrn_pkg::ST_DIV;
      end
      mmrn_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (count == mmrn_pkg::CNT_W'(mmrn_pkg::DIV_STEPS - 1)) begin
          count_next = '0;
          state_next = mmrn_pkg::ST_FIN;
        end else begin
          count_next = count + 1'b1;
        end
      end
      mmrn_pkg::ST_FIN: begin
        if (stat.out_free) begin
          cmd.fin    = 1'b1;
          state_next = mmrn_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mmrn_pkg::ST_IDLE;
      end
    endcase
  end

  `MMRN_ASSERT_NOW(a_div_count_range, state == mmrn_pkg::ST_DIV,
                   count < mmrn_pkg::CNT_W'(mmrn_pkg::DIV_STEPS))
  `MMRN_ASSERT_NEXT(a_div_ends_in_fin,
                    state == mmrn_pkg::ST_DIV &&
                    count == mmrn_pkg::CNT_W'(mmrn_pkg::DIV_STEPS - 1),
                    state == mmrn_pkg::ST_FIN)
  `MMRN_ASSERT_NEXT(a_fin_returns_idle, state == mmrn_pkg::ST_FIN && stat.out_free,
                    state == mmrn_pkg::ST_IDLE)
  `MMRN_ASSERT_NEXT(a_gather_stays_idle, cmd.accept && !stat.req_norm,
                    state == mmrn_pkg::ST_IDLE)

endmodule

// ===== hdl/mmrn_datapath.sv =====
// Datapath of the min-max range normaliser: configuration, running statistics,
// range subtraction, span multiply, shift-subtract divider and result register.
// Depends on mmrn_pkg and the shared assertion header.
`include "min_max_range_normalizer_core_assert.svh"

module mmrn_datapath (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [15:0]     cfg_data,
  input  mmrn_pkg::req_t  req,
  output mmrn_pkg::res_t  res,
  output logic            res_valid,
  input  logic            res_stall,
  input  mmrn_pkg::cmd_t  cmd,
  output mmrn_pkg::stat_t stat
);

  logic [1:0]  raw_format;
  logic [15:0] target_level;
  logic [7:0]  half_span;
  logic [31:0] running_max;
  logic [31:0] running_min;
  logic [31:0] sample;

  logic [31:0] dmag;
  logic [31:0] nmag;
  logic        diff_neg;
  logic        den_neg;
  logic        deg;
  logic        out_band;
  logic        neg;
  logic [31:0] rem;
  logic [mmrn_pkg::QUO_W-1:0] quo;
  mmrn_pkg::res_t out_reg;
  logic           out_valid;

  logic [31:0] base_max, base_min;
  logic [15:0] top;
  logic [31:0] max_c;
  logic [32:0] diff, den, diff_inv, den_inv;
  logic [mmrn_pkg::SPAN2_W-1:0] span2;
  logic [31:0]                  mul_a;
  logic [mmrn_pkg::PROD_W-1:0]  product;
  logic        out_band_now;
  logic        sat_hi;
  logic [32:0] trial;
  logic        trial_ge;
  logic [16:0] lo_whole, hi_whole;
  logic [33:0] lo_q, hi_q, sum_q;
  mmrn_pkg::res_t res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_format   <= mmrn_pkg::FMT_8BIT;
      target_level <= '0;
      half_span    <= 8'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        mmrn_pkg::REG_RAW_FORMAT:   raw_format   <= cfg_data[1:0];
        mmrn_pkg::REG_TARGET_LEVEL: target_level <= cfg_data;
        mmrn_pkg::REG_HALF_SPAN:    half_span    <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  assign base_max = req.first ? '0 : running_max;
  assign base_min = req.first ? '1 : running_min;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_max <= '0;
      running_min <= '1;
    end else if (cmd.accept && req.mode == mmrn_pkg::MODE_GATHER) begin
      running_max <= (req.sample > base_max) ? req.sample : base_max;
      running_min <= (req.sample < base_min) ? req.sample : base_min;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample <= req.sample;
    end
  end

  assign top      = mmrn_pkg::top_code(raw_format);
  assign max_c    = (running_max[31:16] > top) ? {top, 16'h0000} : running_max;
  assign diff     = {1'b0, sample} - {1'b0, running_min};
  assign den      = {1'b0, max_c} - {1'b0, running_min};
  assign diff_inv = 33'd0 - diff;
  assign den_inv  = 33'd0 - den;

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      dmag     <= diff[32] ? diff_inv[31:0] : diff[31:0];
      nmag     <= den[32] ? den_inv[31:0] : den[31:0];
      diff_neg <= diff[32];
      den_neg  <= den[32];
      deg      <= (max_c == running_min);
    end
  end

  assign span2        = {half_span, 1'b0};
  assign mul_a        = cmd.mul ? dmag : rem;
  assign product      = mmrn_pkg::PROD_W'(mul_a) * mmrn_pkg::PROD_W'(span2);
  assign out_band_now = (dmag > nmag) && (half_span != 8'd0);
  assign sat_hi       = (product[mmrn_pkg::PROD_W-1:mmrn_pkg::FRAC_W] != '0) ||
                        ({product[mmrn_pkg::FRAC_W-1:0], mmrn_pkg::FRAC_W'(0)} >= nmag);

  assign trial    = {rem, quo[mmrn_pkg::QUO_W-1]};
  assign trial_ge = (trial >= {1'b0, nmag});

  // Beyond the band the excess over the range is kept, so that the final step can
  // tell a clipped result from one that lands exactly on the upper edge.
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      out_band <= out_band_now;
      neg      <= diff_neg ^ den_neg;
      rem      <= out_band_now ? (dmag - nmag) :
                  product[mmrn_pkg::PROD_W-1:mmrn_pkg::SPAN2_W];
      quo      <= {product[mmrn_pkg::SPAN2_W-1:0], mmrn_pkg::FRAC_W'(0)};
    end else if (cmd.div_step) begin
      rem <= trial_ge ? 32'(trial - {1'b0, nmag}) : trial[31:0];
      quo <= {quo[mmrn_pkg::QUO_W-2:0], trial_ge};
    end
  end

  assign lo_whole = {1'b0, target_level} - {9'b0, half_span};
  assign hi_whole = {1'b0, target_level} + {9'b0, half_span};
  assign lo_q     = {lo_whole[16], lo_whole, 16'h0000};
  assign hi_q     = {1'b0, hi_whole, 16'h0000};
  assign sum_q    = lo_q + 34'(quo);

  always_comb begin
    res_next = '0;
    if (deg) begin
      res_next.value      = lo_q;
      res_next.degenerate = 1'b1;
    end else if (out_band) begin
      res_next.value     = neg ? lo_q : hi_q;
      res_next.saturated = neg || sat_hi;
    end else if (neg && quo != '0) begin
      res_next.value     = lo_q;
      res_next.saturated = 1'b1;
    end else begin
      res_next.value = sum_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin) begin
      out_valid <= 1'b1;
    end else if (!res_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_reg <= res_next;
    end
  end

  assign res       = out_reg;
  assign res_valid = out_valid;

  assign stat.req_norm = (req.mode == mmrn_pkg::MODE_NORMALIZE);
  assign stat.skip_div = deg || out_band_now;
  assign stat.out_free = !out_valid || !res_stall;

  `MMRN_ASSERT_NOW(a_degenerate_not_saturated, out_valid && out_reg.degenerate,
                   !out_reg.saturated)
  `MMRN_ASSERT_NOW(a_fin_only_when_free, cmd.fin, !out_valid || !res_stall)
  `MMRN_ASSERT_NOW(a_remainder_below_divisor, cmd.div_step, rem < nmag)

endmodule
